// File: rtl/core/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared constants and the result type of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SIZE_W  = 16;

    localparam logic [SIZE_W-1:0] HEADER_BYTES   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = SIZE_W'(1024);

    typedef struct packed {
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] frame_slot;
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_valid;
        logic [SIZE_W-1:0] byte_index;
        logic              last;
    } t_result;

endpackage

// File: rtl/core/lpfd_parser.sv
// ----------------------------------------------------------------------------
// lpfd_parser
// Frame state tracker: size field, header bytes and payload position.
// ----------------------------------------------------------------------------
module lpfd_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lpfd_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                      i_accept,
    input  logic [lpfd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                      o_res_valid,
    output lpfd_pkg::t_result         o_res
);
    import lpfd_pkg::*;

    localparam logic [1:0] PH_SIZE_LO = 2'd0;
    localparam logic [1:0] PH_SIZE_HI = 2'd1;
    localparam logic [1:0] PH_BODY    = 2'd2;

    logic [1:0]        r_phase,      n_phase;
    logic [SIZE_W-1:0] r_frame_size, n_frame_size;
    logic [SIZE_W-1:0] r_body_count, n_body_count;
    logic [BYTE_W-1:0] r_held_type,  n_held_type;
    logic [BYTE_W-1:0] r_held_slot,  n_held_slot;
    logic [SIZE_W-1:0] r_max_size;

    logic [SIZE_W-1:0] size_full;
    logic [SIZE_W-1:0] pos_next;
    logic              done;

    assign size_full = {i_rx_byte, r_frame_size[BYTE_W-1:0]};
    assign pos_next  = r_body_count + SIZE_W'(1);
    assign done      = (pos_next == r_frame_size);

    always_comb begin
        n_phase      = r_phase;
        n_frame_size = r_frame_size;
        n_body_count = r_body_count;
        n_held_type  = r_held_type;
        n_held_slot  = r_held_slot;
        o_res_valid  = 1'b0;
        o_res.frame_type   = r_held_type;
        o_res.frame_slot   = r_held_slot;
        o_res.payload_byte = i_rx_byte;
        o_res.byte_valid   = 1'b1;
        o_res.byte_index   = r_body_count - HEADER_BYTES;
        o_res.last         = done;
        unique case (r_phase)
            PH_SIZE_HI: begin
                n_frame_size = size_full;
                if (size_full < HEADER_BYTES || size_full > r_max_size) begin
                    n_phase = PH_SIZE_LO;
                end else begin
                    n_body_count = '0;
                    n_phase      = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_body_count == SIZE_W'(0)) begin
                    n_held_type = i_rx_byte;
                end else if (r_body_count == SIZE_W'(1)) begin
                    n_held_slot        = i_rx_byte;
                    o_res.frame_slot   = i_rx_byte;
                    o_res.payload_byte = '0;
                    o_res.byte_valid   = 1'b0;
                    o_res.byte_index   = '0;
                    o_res.last         = 1'b1;
                    o_res_valid        = done;
                end else begin
                    o_res_valid = 1'b1;
                end
                n_body_count = pos_next;
                if (done) begin
                    n_phase = PH_SIZE_LO;
                end
            end
            default: begin
                n_frame_size = {{(SIZE_W-BYTE_W){1'b0}}, i_rx_byte};
                n_phase      = PH_SIZE_HI;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE_LO;
            r_frame_size <= '0;
            r_body_count <= '0;
            r_held_type  <= '0;
            r_held_slot  <= '0;
            r_max_size   <= MAX_SIZE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_size <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase      <= n_phase;
                r_frame_size <= n_frame_size;
                r_body_count <= n_body_count;
                r_held_type  <= n_held_type;
                r_held_slot  <= n_held_slot;
            end
        end
    end

endmodule

// File: rtl/core/length_prefixed_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_unit
// Parses a byte stream of little-endian size-prefixed frames and streams out
// each payload byte tagged with the frame type, slot, index and last flag.
//
// Channel   Direction  Handshake             Payload
// in        input      i_in_valid/o_in_stall  i_rx_byte
// out       output     o_out_valid/i_out_stall frame_type, frame_slot, payload,
//                                             byte_valid, byte_index, last
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (max_frame_size)
//
// One beat is taken per cycle while the skid entry is empty; each result is
// registered in the output register, or in the skid entry under output stall.
// The rate is set by the single frame state update done per accepted beat.
// The two entries keep input flowing; input stalls only when the skid is full.
// Reset is synchronous and active low and sets max_frame_size to 1024.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lpfd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lpfd_pkg::BYTE_W-1:0] o_frame_type,
    output logic [lpfd_pkg::BYTE_W-1:0] o_frame_slot,
    output logic [lpfd_pkg::BYTE_W-1:0] o_payload_byte,
    output logic                        o_byte_valid,
    output logic [lpfd_pkg::SIZE_W-1:0] o_byte_index,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lpfd_pkg::SIZE_W-1:0] i_cfg_data
);
    import lpfd_pkg::*;

    logic    in_accept;
    logic    take_out;
    logic    res_valid;
    t_result res;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign take_out    = r_out_valid && !i_out_stall;

    lpfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take_out) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || take_out) begin
            r_out_valid <= in_accept && res_valid;
        end else if (in_accept && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take_out) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || take_out) begin
            r_out <= res;
        end else begin
            r_skid <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_type   = r_out.frame_type;
    assign o_frame_slot   = r_out.frame_slot;
    assign o_payload_byte = r_out.payload_byte;
    assign o_byte_valid   = r_out.byte_valid;
    assign o_byte_index   = r_out.byte_index;
    assign o_last         = r_out.last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid entry held without a pending output beat.");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !take_out) |=> (r_skid_valid && $stable(r_skid)))
        else $error("Skid entry lost while output was stalled.");

    a_empty_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |->
            (o_last && o_byte_index == '0 && o_payload_byte == '0))
        else $error("Empty-payload notice carries wrong fields.");

endmodule
